// File: rtl/core/deq_pkg.sv
package deq_pkg;

  // Number of cells in the chain, one stored word per cell.
  localparam int DEPTH = 64;

  // Width of the occupancy counter, wide enough to hold DEPTH itself.
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int WORD_W   = 32;
  localparam int CMD_W    = 3;
  localparam int FILL_W   = 7;
  localparam int STATUS_W = 2;

  // Command codes of the input transaction.
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;

  // Status codes of the result transaction.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_IN,
    CELL_SHIFT_OUT,
    CELL_PUSH_BACK,
    CELL_POP_BACK
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic signed [WORD_W-1:0] word;
  } cell_ctl_t;

endpackage

// File: rtl/core/double_ended_queue_top.sv
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   in_cmd, in_value
// out      output     out_valid/out_stall out_front_value, out_back_value,
//                                         out_fill_count, out_status
//
// One result per input transaction; one transaction per cycle unless in_stall.
// A transaction updates the cell chain at the edge that accepts it; its result
// is loaded into the output register at the first later edge at which the
// output is not blocked. Reset empties the chain at once; no clearing pass.
// While a loaded result is stalled and another result waits, in_stall is high.
module double_ended_queue_top
  import deq_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [CMD_W-1:0]           in_cmd,
  input  logic signed [WORD_W-1:0]   in_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [WORD_W-1:0]   out_front_value,
  output logic signed [WORD_W-1:0]   out_back_value,
  output logic [FILL_W-1:0]          out_fill_count,
  output logic [STATUS_W-1:0]        out_status
);

  logic signed [WORD_W-1:0] cell_data  [DEPTH];
  logic                     cell_valid [DEPTH];
  logic                     cell_last  [DEPTH];

  cell_ctl_t             ctl;
  logic                  in_fire;
  logic                  out_blocked;
  logic                  full;
  logic                  empty;
  logic [STATUS_W-1:0]   status_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  pend_r;
  logic [STATUS_W-1:0]   pend_status_r;
  logic                  out_valid_r;
  logic signed [WORD_W-1:0] front_r, back_r;
  logic [FILL_W-1:0]     fill_r;
  logic [STATUS_W-1:0]   status_r;
  logic signed [WORD_W-1:0] back_sel;

  assign out_blocked = out_valid_r & out_stall;
  assign in_stall    = pend_r & out_blocked;
  assign in_fire     = in_valid & ~in_stall;

  assign full  = cell_valid[DEPTH-1];
  assign empty = ~cell_valid[0];

  // Decode the command into a chain operation, dropping refused ones.
  always_comb begin
    ctl.op      = CELL_HOLD;
    ctl.word    = in_value;
    status_nxt  = ST_OK;
    cnt_nxt     = cnt_r;
    if (in_fire) begin
      unique case (in_cmd) inside
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ctl.op  = (in_cmd == CMD_PUSH_FRONT) ? CELL_SHIFT_IN : CELL_PUSH_BACK;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            ctl.op  = (in_cmd == CMD_POP_FRONT) ? CELL_SHIFT_OUT : CELL_POP_BACK;
            cnt_nxt = cnt_r - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The chain of cells, front word in cell zero.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] l_data, r_data;
    logic                     l_valid, r_valid;

    if (i == 0) begin : g_head
      assign l_data  = in_value;
      assign l_valid = 1'b1;
    end else begin : g_body
      assign l_data  = cell_data[i-1];
      assign l_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_data  = cell_data[i+1];
      assign r_valid = cell_valid[i+1];
    end

    deq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .right_data  (r_data),
      .right_valid (r_valid),
      .data        (cell_data[i]),
      .valid       (cell_valid[i]),
      .last        (cell_last[i])
    );
  end

  // The back word sits in the one cell flagged as last; an empty chain gives 0.
  always_comb begin
    back_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_sel = back_sel | (cell_data[i] & {WORD_W{cell_last[i]}});
    end
  end

  // Count, pending result and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (!out_blocked) begin
        out_valid_r <= pend_r;
      end
      if (in_fire) begin
        pend_r <= 1'b1;
      end else if (!out_blocked) begin
        pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_status_r <= status_nxt;
    end
    if (pend_r && !out_blocked) begin
      front_r  <= cell_valid[0] ? cell_data[0] : '0;
      back_r   <= back_sel;
      fill_r   <= FILL_W'(cnt_r);
      status_r <= pend_status_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_front_value = front_r;
  assign out_back_value  = back_r;
  assign out_fill_count  = fill_r;
  assign out_status      = status_r;

endmodule

// File: rtl/core/deq_cell.sv
module deq_cell
  import deq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cell_ctl_t                ctl,
  input  logic signed [WORD_W-1:0] left_data,
  input  logic                     left_valid,
  input  logic signed [WORD_W-1:0] right_data,
  input  logic                     right_valid,
  output logic signed [WORD_W-1:0] data,
  output logic                     valid,
  output logic                     last
);

  logic signed [WORD_W-1:0] data_r, data_nxt;
  logic                     valid_r, valid_nxt;

  // Next state of this cell from its own contents and its two neighbors.
  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    case (ctl.op)
      CELL_SHIFT_IN: begin
        data_nxt  = left_data;
        valid_nxt = left_valid;
      end
      CELL_SHIFT_OUT: begin
        data_nxt  = right_data;
        valid_nxt = right_valid;
      end
      CELL_PUSH_BACK: begin
        // Only the first empty cell takes the word: the one behind an occupied cell, or the head cell.
        if (!valid_r && left_valid) begin
          data_nxt  = ctl.word;
          valid_nxt = 1'b1;
        end
      end
      CELL_POP_BACK: begin
        valid_nxt = valid_r & right_valid;
      end
      default: begin
      end
    endcase
  end

  // Occupancy is control state; the word itself needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data  = data_r;
  assign valid = valid_r;
  assign last  = valid_r & ~right_valid;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import deq_pkg::*;

  // Command codes that leave the queue untouched.
  localparam logic [CMD_W-1:0] CMD_NONE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

  // Cycles without any accepted transaction before the run is declared hung.
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic signed [WORD_W-1:0] front;
    logic signed [WORD_W-1:0] back;
    logic [FILL_W-1:0]        fill;
    logic [STATUS_W-1:0]      status;
  } deque_view_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [CMD_W-1:0]         in_cmd;
  logic signed [WORD_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [WORD_W-1:0] out_front_value;
  logic signed [WORD_W-1:0] out_back_value;
  logic [FILL_W-1:0]        out_fill_count;
  logic [STATUS_W-1:0]      out_status;

  // Shadow copy of the queue contents and pointers.
  logic signed [WORD_W-1:0] shadow_ring [DEPTH];
  int                       shadow_head;
  int                       shadow_tail;
  int                       shadow_count;

  deque_view_t expected_views [$];
  int          error_count;
  int          mismatch_count;
  int          quiet_cycles;
  bit          idle_on;
  bit          long_hold_req;

  double_ended_queue_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_fill_count  (out_fill_count),
    .out_status      (out_status)
  );

  // Free-running clock, 8 ns period.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Applies one operation to the shadow queue and returns the view after it.
  function automatic deque_view_t predict_deque_op(logic [CMD_W-1:0] cmd,
                                                   logic signed [WORD_W-1:0] word);
    deque_view_t view;
    int          last;
    view.status = ST_OK;
    view.front  = '0;
    view.back   = '0;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          view.status = ST_FULL;
        end else if (cmd == CMD_PUSH_FRONT) begin
          shadow_head = (shadow_head == 0) ? DEPTH - 1 : shadow_head - 1;
          shadow_ring[shadow_head] = word;
          shadow_count++;
        end else begin
          shadow_ring[shadow_tail] = word;
          shadow_tail = (shadow_tail + 1 >= DEPTH) ? 0 : shadow_tail + 1;
          shadow_count++;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (shadow_count == 0) begin
          view.status = ST_EMPTY;
        end else if (cmd == CMD_POP_FRONT) begin
          shadow_head = (shadow_head + 1 >= DEPTH) ? 0 : shadow_head + 1;
          shadow_count--;
        end else begin
          shadow_tail = (shadow_tail == 0) ? DEPTH - 1 : shadow_tail - 1;
          shadow_count--;
        end
      end
      default: begin
      end
    endcase
    // Front and back read zero while the queue is empty.
    if (shadow_count > 0) begin
      last = (shadow_tail == 0) ? DEPTH - 1 : shadow_tail - 1;
      view.front = shadow_ring[shadow_head];
      view.back  = shadow_ring[last];
    end
    view.fill = FILL_W'(shadow_count);
    return view;
  endfunction

  // Word source that favors the extremes now and then.
  function automatic logic signed [WORD_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  // Picks a command; push_pct sets the share of pushes among the items.
  function automatic logic [CMD_W-1:0] random_cmd(int push_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) begin
      return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    end else if (roll < 95) begin
      return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
    end
    return CMD_NONE + CMD_W'($urandom_range(0, 3));
  endfunction

  // Offers one transaction, waits for its acceptance and records its expectation.
  task automatic send_op(logic [CMD_W-1:0] cmd, logic signed [WORD_W-1:0] word);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_value <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_views.push_back(predict_deque_op(cmd, word));
  endtask

  // Stops offering and waits until every expected result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_op(CMD_POP_FRONT, 32'sd17);
    send_op(CMD_POP_BACK, 32'sd18);
    // Push at the back of an empty queue, then pop the single entry.
    send_op(CMD_PUSH_BACK, WORD_MAX);
    send_op(CMD_POP_FRONT, '0);
    send_op(CMD_PUSH_FRONT, WORD_MIN);
    send_op(CMD_POP_BACK, '0);
    send_op(CMD_PUSH_BACK, '0);
    send_op(CMD_PUSH_FRONT, -1);
    send_op(CMD_PUSH_BACK, 32'sd1);
    send_op(CMD_NONE, $urandom);
    send_op(CMD_SPARE_5, $urandom);
    send_op(CMD_SPARE_6, $urandom);
    send_op(CMD_SPARE_7, $urandom);
    send_op(CMD_POP_FRONT, -1);
    send_op(CMD_POP_BACK, -1);
    send_op(CMD_POP_BACK, -1);
    send_op(CMD_POP_FRONT, '0);
    send_op(CMD_PUSH_FRONT, 32'sh5A5A_A5A5);
    send_op(CMD_PUSH_BACK, 32'shA5A5_5A5A);
    send_op(CMD_POP_FRONT, '0);
    send_op(CMD_POP_FRONT, '0);
    send_op(CMD_POP_BACK, '0);
  endtask

  // Random walk whose push share steers the queue toward full or empty.
  task automatic test_random_walk(int items, int push_pct);
    repeat (items) send_op(random_cmd(push_pct), random_word());
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_long_backpressure();
    long_hold_req = 1'b1;
    idle_on = 1'b0;
    repeat (80) send_op(random_cmd(60), random_word());
    idle_on = 1'b1;
  endtask

  // Sender pauses until the queue of expectations is empty, then resumes.
  task automatic test_pause_until_drained();
    drain_results();
    test_random_walk(100, 50);
  endtask

  // Final stretch at full rate on both sides.
  task automatic test_full_rate();
    idle_on = 1'b0;
    test_random_walk(150, 70);
    test_random_walk(150, 30);
  endtask

  // Receiver stall pattern: random bursts, plus one long hold on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        long_hold_req = 1'b0;
      end else if (idle_on && rst_n && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void note_mismatch(string field, logic [WORD_W-1:0] exp_val,
                                        logic [WORD_W-1:0] act_val);
    error_count++;
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("Mismatch on %s: expected %0h, got %0h", field, exp_val, act_val);
    end
  endfunction

  // Result checker: every accepted result is compared with the oldest expectation.
  always @(posedge clk) begin
    deque_view_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_views.size() == 0) begin
        error_count++;
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("Result transaction with no expectation waiting");
        end
      end else begin
        want = expected_views.pop_front();
        if (out_front_value !== want.front) begin
          note_mismatch("front_value", want.front, out_front_value);
        end
        if (out_back_value !== want.back) begin
          note_mismatch("back_value", want.back, out_back_value);
        end
        if (out_fill_count !== want.fill) begin
          note_mismatch("fill_count", WORD_W'(want.fill), WORD_W'(out_fill_count));
        end
        if (out_status !== want.status) begin
          note_mismatch("status", WORD_W'(want.status), WORD_W'(out_status));
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_cmd        = CMD_NONE;
    in_value      = '0;
    error_count   = 0;
    mismatch_count = 0;
    quiet_cycles  = 0;
    idle_on       = 1'b1;
    long_hold_req = 1'b0;
    shadow_head   = 0;
    shadow_tail   = 0;
    shadow_count  = 0;
    foreach (shadow_ring[i]) shadow_ring[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_walk(250, 85);
    test_random_walk(250, 15);
    test_random_walk(150, 50);
    test_long_backpressure();
    test_pause_until_drained();
    test_full_rate();

    // Let the pipeline empty before the verdict.
    drain_results();
    repeat (8) @(posedge clk);
    if (error_count == 0 && expected_views.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/deq_pkg.sv
rtl/core/deq_cell.sv
rtl/core/double_ended_queue_top.sv
tb/testbench.sv
